/* rtl/rgbnv_pkg.sv */
package rgbnv_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int QUEUE_DEPTH    = 4;

    localparam int COEF_Y_R = 66;
    localparam int COEF_Y_G = 129;
    localparam int COEF_Y_B = 25;
    localparam int COEF_U_R = 38;
    localparam int COEF_U_G = 74;
    localparam int COEF_U_B = 112;
    localparam int COEF_V_R = 112;
    localparam int COEF_V_G = 94;
    localparam int COEF_V_B = 18;
    localparam int ROUND_HALF = 128;
    localparam int LUMA_OFS  = 16;
    // rounding plus the chroma offset of 128 in the pre-shift domain
    localparam int CHROMA_BIAS = 128 + 32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACT_WIDTH  = 3'd0,
        CFG_ACT_HEIGHT = 3'd1,
        CFG_ROW_STRIDE = 3'd2,
        CFG_PLANE_ROWS = 3'd3,
        CFG_BLUE_FIRST = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] act_width;
        logic [CFG_W-1:0] act_height;
        logic [CFG_W-1:0] row_stride;
        logic [CFG_W-1:0] plane_rows;
        logic             blue_first;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        act_width:  13'd1920,
        act_height: 13'd1080,
        row_stride: 13'd1920,
        plane_rows: 13'd1088,
        blue_first: 1'b0
    };

    // classified pixel: channels, block averages and flags
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] avg_r;
        logic [7:0] avg_g;
        logic [7:0] avg_b;
        logic       chroma_valid;
        logic       frame_end;
    } t_pix_cls;

endpackage

/* rtl/rgbnv_fifo.sv */
module rgbnv_fifo
    import rgbnv_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count out of range");

endmodule

/* rtl/rgbnv_front.sv */
module rgbnv_front
    import rgbnv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH),
    localparam int RW = ($clog2(MAX_HEIGHT) < 2) ? 2 : $clog2(MAX_HEIGHT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_push,
    output logic          o_full,
    input  logic [7:0]    i_chan_first,
    input  logic [7:0]    i_chan_second,
    input  logic [7:0]    i_chan_third,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [CW-1:0] o_col,
    output logic [RW-1:0] o_row,
    output t_pix_cls      o_cls
);

    localparam int DW    = CW + 1;
    localparam int HW    = RW + 1;
    localparam int IW    = CW - 1;
    localparam int DEPTH = (MAX_WIDTH + 1) / 2;

    logic [DW-1:0] w;
    logic [HW-1:0] h;

    logic [CW-1:0] r_col, n_col, col_cur;
    logic [RW-1:0] r_row, n_row, row_cur;
    logic [HW-1:0] row_inc;
    logic          wrap_col;
    logic          last_col, last_row;
    logic          accept;

    logic [7:0]    px_r, px_b;
    logic [7:0]    r_pair_r, r_pair_g, r_pair_b;
    logic [8:0]    hs_r, hs_g, hs_b;
    logic [26:0]   hsum;
    logic          closes_h;
    logic [IW-1:0] idx;
    logic          st_wr;

    logic [26:0]   r_store [DEPTH];
    logic [26:0]   r_prev;

    logic          r_f_valid;
    logic [CW-1:0] r_f_col;
    logic [RW-1:0] r_f_row;
    logic [7:0]    r_f_r, r_f_g, r_f_b;
    logic [26:0]   r_f_hsum;
    logic          r_f_cvalid;
    logic          r_f_fend;

    logic [9:0]    s_r, s_g, s_b;
    logic [1:0]    sh;

    // effective geometry: zero reads as one, large values saturate
    always_comb begin
        if (i_cfg.act_width == '0) begin
            w = DW'(1);
        end else if ({1'b0, i_cfg.act_width} > 14'(MAX_WIDTH)) begin
            w = DW'(MAX_WIDTH);
        end else begin
            w = DW'(i_cfg.act_width);
        end
        if (i_cfg.act_height == '0) begin
            h = HW'(1);
        end else if ({1'b0, i_cfg.act_height} > 14'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(i_cfg.act_height);
        end
    end

    assign o_full = r_f_valid && !i_ready;
    assign accept = i_push && !o_full;

    // position of this pixel, wrapped against the current geometry
    always_comb begin
        wrap_col = (DW'(r_col) >= w);
        row_inc  = wrap_col ? HW'(r_row) + 1'b1 : HW'(r_row);
        row_cur  = (row_inc >= h) ? '0 : RW'(row_inc);
        col_cur  = wrap_col ? '0 : r_col;
        last_col = (DW'(col_cur) == w - 1'b1);
        last_row = (HW'(row_cur) == h - 1'b1);
        n_col    = last_col ? '0 : col_cur + 1'b1;
        n_row    = last_col ? (last_row ? '0 : row_cur + 1'b1) : row_cur;
    end

    assign px_r = i_cfg.blue_first ? i_chan_third : i_chan_first;
    assign px_b = i_cfg.blue_first ? i_chan_first : i_chan_third;

    assign hs_r     = col_cur[0] ? 9'(r_pair_r) + 9'(px_r) : 9'(px_r);
    assign hs_g     = col_cur[0] ? 9'(r_pair_g) + 9'(i_chan_second) : 9'(i_chan_second);
    assign hs_b     = col_cur[0] ? 9'(r_pair_b) + 9'(px_b) : 9'(px_b);
    assign hsum     = {hs_b, hs_g, hs_r};
    assign closes_h = col_cur[0] || last_col;
    assign idx      = col_cur[CW-1:1];
    assign st_wr    = accept && closes_h && !row_cur[0] && !last_row;

    always_ff @(posedge i_clk) begin
        if (st_wr) begin
            r_store[idx] <= hsum;
        end
        if (accept) begin
            r_prev <= r_store[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_pair_r  <= '0;
            r_pair_g  <= '0;
            r_pair_b  <= '0;
            r_f_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_f_valid <= 1'b1;
                if (!col_cur[0]) begin
                    r_pair_r <= px_r;
                    r_pair_g <= i_chan_second;
                    r_pair_b <= px_b;
                end
            end else if (i_ready) begin
                r_f_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_col    <= col_cur;
            r_f_row    <= row_cur;
            r_f_r      <= px_r;
            r_f_g      <= i_chan_second;
            r_f_b      <= px_b;
            r_f_hsum   <= hsum;
            r_f_cvalid <= closes_h && (row_cur[0] || last_row);
            r_f_fend   <= last_col && last_row;
        end
    end

    // block averages: odd rows add the stored even-row pair
    always_comb begin
        if (r_f_row[0]) begin
            s_r = 10'(r_prev[8:0])   + 10'(r_f_hsum[8:0]);
            s_g = 10'(r_prev[17:9])  + 10'(r_f_hsum[17:9]);
            s_b = 10'(r_prev[26:18]) + 10'(r_f_hsum[26:18]);
            sh  = r_f_col[0] ? 2'd2 : 2'd1;
        end else begin
            s_r = 10'(r_f_hsum[8:0]);
            s_g = 10'(r_f_hsum[17:9]);
            s_b = 10'(r_f_hsum[26:18]);
            sh  = r_f_col[0] ? 2'd1 : 2'd0;
        end
        o_cls.r            = r_f_r;
        o_cls.g            = r_f_g;
        o_cls.b            = r_f_b;
        o_cls.avg_r        = 8'(s_r >> sh);
        o_cls.avg_g        = 8'(s_g >> sh);
        o_cls.avg_b        = 8'(s_b >> sh);
        o_cls.chroma_valid = r_f_cvalid;
        o_cls.frame_end    = r_f_fend;
    end

    assign o_valid = r_f_valid;
    assign o_col   = r_f_col;
    assign o_row   = r_f_row;

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last_col && last_row |=> r_col == '0 && r_row == '0)
        else $error("position not at origin after last pixel");

endmodule

/* rtl/rgbnv_back.sv */
module rgbnv_back
    import rgbnv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH),
    localparam int RW = ($clog2(MAX_HEIGHT) < 2) ? 2 : $clog2(MAX_HEIGHT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_valid,
    output logic          o_take,
    input  logic [CW-1:0] i_col,
    input  logic [RW-1:0] i_row,
    input  t_pix_cls      i_cls,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [23:0]   o_luma_addr,
    output logic [7:0]    o_luma_val,
    output logic          o_chroma_valid,
    output logic [24:0]   o_chroma_addr,
    output logic [7:0]    o_u_val,
    output logic [7:0]    o_v_val,
    output logic          o_frame_end
);

    localparam int LPW = RW + CFG_W;
    localparam int CBW = CFG_W + 1;
    localparam int CPW = CBW + CFG_W;

    logic          b1_ready, b2_ready;

    logic [LPW-1:0] l_prod;
    logic [15:0]    y_sum, u_sum, v_sum;

    logic           r_b1_vld;
    logic [CW-1:0]  r_b1_col;
    logic [RW-1:0]  r_b1_row;
    logic [23:0]    r_b1_luma_addr;
    logic [7:0]     r_b1_y;
    logic [7:0]     r_b1_u_val;
    logic [7:0]     r_b1_v_val;
    logic           r_b1_cvalid;
    logic           r_b1_fend;

    logic [CBW-1:0] c_base;
    logic [CPW-1:0] c_prod;
    logic [24:0]    c_addr;

    logic           r_b2_vld;
    logic [23:0]    r_b2_luma_addr;
    logic [7:0]     r_b2_luma_val;
    logic           r_b2_cvalid;
    logic [24:0]    r_b2_chroma_addr;
    logic [7:0]     r_b2_u_val;
    logic [7:0]     r_b2_v_val;
    logic           r_b2_fend;

    assign b2_ready = !r_b2_vld || i_pop;
    assign b1_ready = !r_b1_vld || b2_ready;
    assign o_take   = i_valid && b1_ready;
    assign o_empty  = !r_b2_vld;

    assign l_prod = LPW'(i_row) * LPW'(i_cfg.row_stride);

    // sums stay within 0..65535, so 16-bit wrap arithmetic is exact
    assign y_sum = 16'(COEF_Y_R) * 16'(i_cls.r) + 16'(COEF_Y_G) * 16'(i_cls.g)
                 + 16'(COEF_Y_B) * 16'(i_cls.b) + 16'(ROUND_HALF);
    assign u_sum = 16'(COEF_U_B) * 16'(i_cls.avg_b) + 16'(CHROMA_BIAS)
                 - 16'(COEF_U_R) * 16'(i_cls.avg_r) - 16'(COEF_U_G) * 16'(i_cls.avg_g);
    assign v_sum = 16'(COEF_V_R) * 16'(i_cls.avg_r) + 16'(CHROMA_BIAS)
                 - 16'(COEF_V_G) * 16'(i_cls.avg_g) - 16'(COEF_V_B) * 16'(i_cls.avg_b);

    assign c_base = CBW'(i_cfg.plane_rows) + CBW'(r_b1_row >> 1);
    assign c_prod = CPW'(c_base) * CPW'(i_cfg.row_stride);
    assign c_addr = 25'(c_prod) + 25'({r_b1_col[CW-1:1], 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
        end else begin
            if (b1_ready) begin
                r_b1_vld <= i_valid;
            end
            if (b2_ready) begin
                r_b2_vld <= r_b1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_b1_col       <= i_col;
            r_b1_row       <= i_row;
            r_b1_luma_addr <= 24'(l_prod) + 24'(i_col);
            r_b1_y         <= y_sum[15:8] + 8'(LUMA_OFS);
            r_b1_u_val     <= i_cls.chroma_valid ? u_sum[15:8] : '0;
            r_b1_v_val     <= i_cls.chroma_valid ? v_sum[15:8] : '0;
            r_b1_cvalid    <= i_cls.chroma_valid;
            r_b1_fend      <= i_cls.frame_end;
        end
        if (r_b1_vld && b2_ready) begin
            r_b2_luma_addr   <= r_b1_luma_addr;
            r_b2_luma_val    <= r_b1_y;
            r_b2_cvalid      <= r_b1_cvalid;
            r_b2_chroma_addr <= r_b1_cvalid ? c_addr : '0;
            r_b2_u_val       <= r_b1_u_val;
            r_b2_v_val       <= r_b1_v_val;
            r_b2_fend        <= r_b1_fend;
        end
    end

    assign o_luma_addr    = r_b2_luma_addr;
    assign o_luma_val     = r_b2_luma_val;
    assign o_chroma_valid = r_b2_cvalid;
    assign o_chroma_addr  = r_b2_chroma_addr;
    assign o_u_val        = r_b2_u_val;
    assign o_v_val        = r_b2_v_val;
    assign o_frame_end    = r_b2_fend;

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b1_vld && !b2_ready |=> r_b1_vld)
        else $error("stalled stage lost its item");

    a_end_has_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && r_b2_fend |-> r_b2_cvalid)
        else $error("last pixel of frame without chroma");

endmodule

/* rtl/rgb_to_nv12_converter.sv */
// A pushed pixel passes the line store read, the queue and two arithmetic
// stages in that order before its result shows on the output ports.
// Throughput: one pixel per cycle while pop drains the output, set by the
// single-port line store at the front and two multiply stages at the back.
// Reset: synchronous, active low; clears position counters, queues and
// registers to defaults. The chroma line store is not cleared.
module rgb_to_nv12_converter
    import rgbnv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_chan_first,
    input  logic [7:0]           i_chan_second,
    input  logic [7:0]           i_chan_third,
    output logic                 empty,
    input  logic                 pop,
    output logic [23:0]          o_luma_addr,
    output logic [7:0]           o_luma_val,
    output logic                 o_chroma_valid,
    output logic [24:0]          o_chroma_addr,
    output logic [7:0]           o_u_val,
    output logic [7:0]           o_v_val,
    output logic                 o_frame_end
);

    localparam int CW = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
    localparam int RW = ($clog2(MAX_HEIGHT) < 2) ? 2 : $clog2(MAX_HEIGHT);
    localparam int QW = CW + RW + $bits(t_pix_cls);

    t_cfg          r_cfg;

    logic          f_valid;
    logic [CW-1:0] f_col;
    logic [RW-1:0] f_row;
    t_pix_cls      f_cls;
    logic          q_full;
    logic          q_empty;
    logic          q_take;
    logic [QW-1:0] q_rd;
    logic [CW-1:0] q_col;
    logic [RW-1:0] q_row;
    t_pix_cls      q_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ACT_WIDTH:  r_cfg.act_width  <= i_cfg_wdata;
                CFG_ACT_HEIGHT: r_cfg.act_height <= i_cfg_wdata;
                CFG_ROW_STRIDE: r_cfg.row_stride <= i_cfg_wdata;
                CFG_PLANE_ROWS: r_cfg.plane_rows <= i_cfg_wdata;
                CFG_BLUE_FIRST: r_cfg.blue_first <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    rgbnv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .o_full        (full),
        .i_chan_first  (i_chan_first),
        .i_chan_second (i_chan_second),
        .i_chan_third  (i_chan_third),
        .o_valid       (f_valid),
        .i_ready       (!q_full),
        .o_col         (f_col),
        .o_row         (f_row),
        .o_cls         (f_cls)
    );

    rgbnv_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_col, f_row, f_cls}),
        .o_full  (q_full),
        .i_pop   (q_take),
        .o_data  (q_rd),
        .o_empty (q_empty)
    );

    assign {q_col, q_row, q_cls} = q_rd;

    rgbnv_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (!q_empty),
        .o_take         (q_take),
        .i_col          (q_col),
        .i_row          (q_row),
        .i_cls          (q_cls),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_luma_addr    (o_luma_addr),
        .o_luma_val     (o_luma_val),
        .o_chroma_valid (o_chroma_valid),
        .o_chroma_addr  (o_chroma_addr),
        .o_u_val        (o_u_val),
        .o_v_val        (o_v_val),
        .o_frame_end    (o_frame_end)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import rgbnv_pkg::*;

    localparam int STORE_ENTRIES = (DEF_MAX_WIDTH + 1) / 2;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PIXELS = 1600;

    typedef struct packed {
        logic [23:0] luma_addr;
        logic [7:0]  luma_val;
        logic        chroma_valid;
        logic [24:0] chroma_addr;
        logic [7:0]  u_val;
        logic [7:0]  v_val;
        logic        frame_end;
    } t_nv12_sample;

    typedef struct packed {
        logic [8:0] r;
        logic [8:0] g;
        logic [8:0] b;
    } t_chan_sum;

    typedef enum logic {STEP_CFG, STEP_PIX} t_step_kind;

    typedef struct {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic [7:0]           chan [3];
        bit                   known;
        t_nv12_sample         result;
    } t_dir_step;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [7:0]           i_chan_first = '0;
    logic [7:0]           i_chan_second = '0;
    logic [7:0]           i_chan_third = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [23:0]          o_luma_addr;
    logic [7:0]           o_luma_val;
    logic                 o_chroma_valid;
    logic [24:0]          o_chroma_addr;
    logic [7:0]           o_u_val;
    logic [7:0]           o_v_val;
    logic                 o_frame_end;

    rgb_to_nv12_converter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_chan_first   (i_chan_first),
        .i_chan_second  (i_chan_second),
        .i_chan_third   (i_chan_third),
        .empty          (empty),
        .pop            (pop),
        .o_luma_addr    (o_luma_addr),
        .o_luma_val     (o_luma_val),
        .o_chroma_valid (o_chroma_valid),
        .o_chroma_addr  (o_chroma_addr),
        .o_u_val        (o_u_val),
        .o_v_val        (o_v_val),
        .o_frame_end    (o_frame_end)
    );

    always #5 i_clk = ~i_clk;

    t_cfg         cfg_shadow = CFG_RESET;
    int unsigned  col_pos = 0;
    int unsigned  row_pos = 0;
    t_chan_sum    pend_pair = '0;
    t_chan_sum    line_sums [STORE_ENTRIES];
    t_nv12_sample pending_samples [$];
    t_dir_step    directed_steps [$];
    int           error_count = 0;
    bit           send_burst = 1'b0;

    function automatic int unsigned dim_limit(logic [CFG_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : 32'(v);
    endfunction

    function automatic logic [7:0] clip8(int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return 8'(v);
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_ACT_WIDTH:  cfg_shadow.act_width = data;
            CFG_ACT_HEIGHT: cfg_shadow.act_height = data;
            CFG_ROW_STRIDE: cfg_shadow.row_stride = data;
            CFG_PLANE_ROWS: cfg_shadow.plane_rows = data;
            CFG_BLUE_FIRST: cfg_shadow.blue_first = data[0];
            default: ;
        endcase
    endfunction

    // advances the raster position and line store, returns the NV12 sample
    function automatic t_nv12_sample convert_pixel(logic [7:0] c_first, c_green, c_third);
        t_nv12_sample res;
        int unsigned  w, h, col, row, idx, shift;
        int           red, grn, blu, yv, ar, ag, ab, uu, vv, sum_r, sum_g, sum_b;
        t_chan_sum    pix, hsum, prev;
        bit           last_col, last_row, odd_col, valid;
        logic [63:0]  addr;
        w = dim_limit(cfg_shadow.act_width, DEF_MAX_WIDTH);
        h = dim_limit(cfg_shadow.act_height, DEF_MAX_HEIGHT);
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        col = col_pos;
        row = row_pos;
        last_col = (col == w - 1);
        last_row = (row == h - 1);
        red = int'(cfg_shadow.blue_first ? c_third : c_first);
        blu = int'(cfg_shadow.blue_first ? c_first : c_third);
        grn = int'(c_green);
        res = '0;
        yv = ((66 * red + 129 * grn + 25 * blu + 128) >>> 8) + 16;
        res.luma_val = clip8(yv);

        pix.r = 9'(red);
        pix.g = 9'(grn);
        pix.b = 9'(blu);
        odd_col = col[0];
        if (odd_col) begin
            hsum.r = pend_pair.r + pix.r;
            hsum.g = pend_pair.g + pix.g;
            hsum.b = pend_pair.b + pix.b;
        end else begin
            hsum = pix;
            pend_pair = pix;
        end
        valid = 1'b0;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        idx = col >> 1;
        shift = odd_col ? 1 : 0;
        if (odd_col || last_col) begin
            if (!row[0]) begin
                if (last_row) begin
                    sum_r = int'(hsum.r);
                    sum_g = int'(hsum.g);
                    sum_b = int'(hsum.b);
                    valid = 1'b1;
                end else begin
                    line_sums[idx] = hsum;
                end
            end else begin
                prev = line_sums[idx];
                sum_r = int'(prev.r) + int'(hsum.r);
                sum_g = int'(prev.g) + int'(hsum.g);
                sum_b = int'(prev.b) + int'(hsum.b);
                shift++;
                valid = 1'b1;
            end
        end
        if (valid) begin
            ar = sum_r >> shift;
            ag = sum_g >> shift;
            ab = sum_b >> shift;
            uu = (-38 * ar - 74 * ag + 112 * ab + 128 + 32768) >>> 8;
            vv = (112 * ar - 94 * ag - 18 * ab + 128 + 32768) >>> 8;
            res.chroma_valid = 1'b1;
            res.u_val = clip8(uu);
            res.v_val = clip8(vv);
            addr = 64'(cfg_shadow.plane_rows) * 64'(cfg_shadow.row_stride)
                + 64'(row >> 1) * 64'(cfg_shadow.row_stride) + 64'(col & 32'hFFFF_FFFE);
            res.chroma_addr = addr[24:0];
        end
        addr = 64'(row) * 64'(cfg_shadow.row_stride) + 64'(col);
        res.luma_addr = addr[23:0];
        res.frame_end = last_col && last_row;

        col_pos = col + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h) row_pos = 0;
        end
        return res;
    endfunction

    function automatic void dir_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        t_dir_step s;
        s.kind = STEP_CFG;
        s.idx = idx;
        s.data = data;
        s.chan = '{8'd0, 8'd0, 8'd0};
        s.known = 1'b0;
        s.result = '0;
        directed_steps.push_back(s);
    endfunction

    function automatic void dir_pix(logic [7:0] a, g, c, bit known = 1'b0,
                                    t_nv12_sample result = '0);
        t_dir_step s;
        s.kind = STEP_PIX;
        s.idx = '0;
        s.data = '0;
        s.chan = '{a, g, c};
        s.known = known;
        s.result = result;
        directed_steps.push_back(s);
    endfunction

    function automatic logic [7:0] rand_chan();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_samples.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        apply_cfg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_pixel(logic [7:0] a, g, c, bit known, t_nv12_sample result);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_chan_first <= a;
        i_chan_second <= g;
        i_chan_third <= c;
        do @(posedge i_clk); while (full);
        if (known) begin
            void'(convert_pixel(a, g, c));
            pending_samples.push_back(result);
        end else begin
            pending_samples.push_back(convert_pixel(a, g, c));
        end
        @(negedge i_clk);
    endtask

    task automatic run_phase(logic [CFG_W-1:0] w, h, stride, planes, bf, int unsigned total);
        wait_idle();
        write_reg(CFG_ACT_WIDTH, w);
        write_reg(CFG_ACT_HEIGHT, h);
        write_reg(CFG_ROW_STRIDE, stride);
        write_reg(CFG_PLANE_ROWS, planes);
        write_reg(CFG_BLUE_FIRST, bf);
        send_burst = ($urandom_range(0, 3) == 0);
        repeat (total) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    initial begin : stimulus
        int unsigned          random_pixels;
        int unsigned          pixels;
        int                   frames;
        logic [CFG_W-1:0]     w, h, stride, planes;
        t_nv12_sample         one_px;

        // defaults after reset: first row of a 1920x1080 frame
        dir_pix(8'd0, 8'd0, 8'd0, 1'b1, '{luma_addr: 24'd0, luma_val: 8'd16, default: '0});
        dir_pix(8'd255, 8'd255, 8'd255, 1'b1,
                '{luma_addr: 24'd1, luma_val: 8'd235, default: '0});
        dir_pix(8'd255, 8'd0, 8'd0);
        dir_pix(8'd0, 8'd0, 8'd255);
        // shrink geometry mid-frame: position wraps to the next frame
        dir_cfg(CFG_ACT_WIDTH, 13'd4);
        dir_cfg(CFG_ACT_HEIGHT, 13'd1);
        dir_pix(8'd0, 8'd255, 8'd0);
        dir_pix(8'd255, 8'd0, 8'd255);
        dir_pix(8'd0, 8'd255, 8'd0);
        dir_pix(8'd255, 8'd255, 8'd255);
        // zero width and height act as 1x1
        dir_cfg(CFG_ACT_WIDTH, 13'd0);
        dir_cfg(CFG_ACT_HEIGHT, 13'd0);
        one_px = '{luma_addr: 24'd0, luma_val: 8'd235, chroma_valid: 1'b1,
                   chroma_addr: 25'd2088960, u_val: 8'd128, v_val: 8'd128, frame_end: 1'b1};
        dir_pix(8'd255, 8'd255, 8'd255, 1'b1, one_px);
        one_px.luma_val = 8'd16;
        dir_pix(8'd0, 8'd0, 8'd0, 1'b1, one_px);
        // 3x3 frame: 2x2, 1x2, 2x1 and 1x1 blocks, BGR order
        dir_cfg(CFG_ACT_WIDTH, 13'd3);
        dir_cfg(CFG_ACT_HEIGHT, 13'd3);
        dir_cfg(CFG_ROW_STRIDE, 13'd5);
        dir_cfg(CFG_PLANE_ROWS, 13'd3);
        dir_cfg(CFG_BLUE_FIRST, 13'h1FFF);
        for (int k = int'(CFG_BLUE_FIRST) + 1; k < 2 ** CFG_IDX_W; k++)
            dir_cfg(CFG_IDX_W'(k), CFG_W'($urandom));
        dir_pix(8'd255, 8'd0, 8'd0);
        dir_pix(8'd0, 8'd255, 8'd0);
        dir_pix(8'd0, 8'd0, 8'd255);
        dir_pix(8'd255, 8'd255, 8'd255);
        dir_pix(8'd0, 8'd0, 8'd0);
        dir_pix(8'd255, 8'd0, 8'd255);
        dir_pix(8'd0, 8'd255, 8'd255);
        dir_pix(8'd255, 8'd255, 8'd0);
        dir_pix(8'd128, 8'd127, 8'd1);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_CFG) begin
                wait_idle();
                write_reg(directed_steps[i].idx, directed_steps[i].data);
            end else begin
                send_pixel(directed_steps[i].chan[0], directed_steps[i].chan[1],
                           directed_steps[i].chan[2], directed_steps[i].known,
                           directed_steps[i].result);
            end
        end

        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:       w = 13'd0;
                1, 2:    w = CFG_W'($urandom_range(13, 48));
                default: w = CFG_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       h = 13'd0;
                1:       h = CFG_W'($urandom_range(7, 16));
                default: h = CFG_W'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 3))
                0:       stride = CFG_W'($urandom_range(0, 8191));
                1:       stride = CFG_W'($urandom_range(0, w));
                default: stride = CFG_W'(w + $urandom_range(0, 16));
            endcase
            if ($urandom_range(0, 2) == 0) planes = CFG_W'($urandom_range(0, 8191));
            else planes = CFG_W'(h + $urandom_range(0, 8));
            frames = $urandom_range(1, 3);
            pixels = frames * dim_limit(w, DEF_MAX_WIDTH) * dim_limit(h, DEF_MAX_HEIGHT);
            run_phase(w, h, stride, planes, CFG_W'($urandom), pixels);
            random_pixels += pixels;
        end

        // oversized width, short run; large stride, plane rows wrap chroma addresses
        run_phase(13'h1FFF, 13'd1, 13'h1FFF, 13'h1FFF, 13'd0, 40);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin : result_side
        int           gap;
        int           left;
        bit           recv_burst;
        t_nv12_sample got;
        t_nv12_sample want;
        left = 0;
        recv_burst = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (left == 0) begin
                recv_burst = ($urandom_range(0, 3) == 0);
                left = $urandom_range(20, 200);
            end
            left--;
            gap = recv_burst ? 0 : $urandom_range(0, 11);
            repeat (gap) begin
                pop <= 1'b0;
                @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            got = {o_luma_addr, o_luma_val, o_chroma_valid, o_chroma_addr,
                   o_u_val, o_v_val, o_frame_end};
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected transfer, expected none actual %h", $time, got);
                error_count++;
            end else begin
                want = pending_samples.pop_front();
                check_field("luma_addr", 32'(want.luma_addr), 32'(got.luma_addr));
                check_field("luma_val", 32'(want.luma_val), 32'(got.luma_val));
                check_field("chroma_valid", 32'(want.chroma_valid), 32'(got.chroma_valid));
                check_field("chroma_addr", 32'(want.chroma_addr), 32'(got.chroma_addr));
                check_field("u_val", 32'(want.u_val), 32'(got.u_val));
                check_field("v_val", 32'(want.v_val), 32'(got.v_val));
                check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
            end
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || i_cfg_wr_en || !i_rst_n) quiet = 0;
            else quiet++;
        end
        $display("testbench: done, errors");
        $finish;
    end

endmodule
